/* hw/rtl/lbfs_pkg.sv */
package lbfs_pkg;

   // character codes
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;

   // position and field counters saturate here
   localparam int unsigned POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   // configuration register map
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATOR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_ONLY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_BASE  = 3'd4;

   // range reset: low 1, high 0, which is empty
   localparam logic [CSR_DATA_W-1:0] RANGE_RESET = 32'd1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FLUSH = 3'b010,
      ST_TAIL  = 3'b100
   } lbfs_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic issue;
      logic load_flush;
      logic load_tail;
   } lbfs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic need_flush;
      logic issue_more;
      logic q_valid;
      logic left_one;
      logic tail_held;
   } lbfs_status_type;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      sat_inc = (v == POS_MAX) ? v : v + POS_W'(1);
   endfunction

endpackage

/* hw/rtl/lbfs_ctrl.sv */
module lbfs_ctrl
   import lbfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  lbfs_status_type status,
   output lbfs_cmd_type    cmd
);

   lbfs_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = status.out_free;
            cmd.accept = req_valid & status.out_free;
            if (cmd.accept && status.need_flush) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // keep one store read in flight ahead of the output register
            cmd.load_flush = status.q_valid & status.out_free;
            cmd.issue      = status.issue_more & (~status.q_valid | status.out_free);
            if (cmd.load_flush && status.left_one) begin
               state_in = status.tail_held ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            cmd.load_tail = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lbfs_datapath.sv */
module lbfs_datapath
   import lbfs_pkg::*;
#(
   parameter int unsigned NUM_RANGES        = 4,
   parameter int unsigned FIRST_FIELD_DEPTH = 63
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_cmd,
   input  logic [7:0]            req_data_byte,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   input  lbfs_cmd_type          cmd,
   output lbfs_status_type       status
);

   localparam int unsigned CNT_W  = $clog2(FIRST_FIELD_DEPTH + 1);
   localparam int unsigned ADDR_W = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;

   // configuration
   logic                  mode_ff, invert_ff, donly_ff;
   logic [7:0]            sep_ff;
   logic [CSR_DATA_W-1:0] range_ff [NUM_RANGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         invert_ff <= 1'b0;
         sep_ff    <= CH_TAB;
         donly_ff  <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_FIELD_MODE) mode_ff   <= csr_data[0];
         if (csr_index == CSR_INVERT)     invert_ff <= csr_data[0];
         if (csr_index == CSR_SEPARATOR)  sep_ff    <= csr_data[7:0];
         if (csr_index == CSR_DELIM_ONLY) donly_ff  <= csr_data[0];
      end
   end

   for (genvar r = 0; r < NUM_RANGES; r++) begin : g_range
      always_ff @(posedge clock) begin
         if (reset) begin
            range_ff[r] <= RANGE_RESET;
         end else if (csr_valid && csr_index == CSR_RANGE_BASE + CSR_IDX_W'(r)) begin
            range_ff[r] <= csr_data;
         end
      end
   end

   // line state
   logic [POS_W-1:0] col_ff, col_in, fld_ff, fld_in;
   logic             delim_ff, delim_in, started_ff, started_in, pending_ff, pending_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // range match for the current position and the next field number
   logic [POS_W-1:0] pos_cur, fld_next;
   logic             hit_cur, hit_next, sel_cur, sel_next;

   assign pos_cur  = mode_ff ? fld_ff : col_ff;
   assign fld_next = sat_inc(fld_ff);

   always_comb begin
      hit_cur  = 1'b0;
      hit_next = 1'b0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         if (pos_cur >= range_ff[r][15:0] && pos_cur <= range_ff[r][31:16]) hit_cur = 1'b1;
         if (fld_next >= range_ff[r][15:0] && fld_next <= range_ff[r][31:16]) hit_next = 1'b1;
      end
      sel_cur  = hit_cur ^ invert_ff;
      sel_next = hit_next ^ invert_ff;
   end

   // request decode
   logic       is_finish, is_data, flush_req, tail_valid, store_we, started_now, need_flush;
   logic [7:0] tail_byte;

   assign is_finish = req_cmd ? pending_ff : (req_data_byte == CH_LF);
   assign is_data   = ~req_cmd & (req_data_byte != CH_LF) & (req_data_byte != CH_CR);

   always_comb begin
      col_in      = col_ff;
      fld_in      = fld_ff;
      delim_in    = delim_ff;
      started_in  = started_ff;
      pending_in  = pending_ff;
      cnt_in      = cnt_ff;
      store_we    = 1'b0;
      flush_req   = 1'b0;
      tail_valid  = 1'b0;
      tail_byte   = req_data_byte;
      started_now = 1'b0;
      if (is_finish) begin
         if (mode_ff && !delim_ff) begin
            // no delimiter: pass the stored line through unless suppressed
            if (!donly_ff) begin
               flush_req  = 1'b1;
               tail_valid = 1'b1;
               tail_byte  = CH_LF;
            end
         end else begin
            tail_valid = 1'b1;
            tail_byte  = CH_LF;
         end
         col_in     = POS_W'(1);
         fld_in     = POS_W'(1);
         delim_in   = 1'b0;
         started_in = 1'b0;
         pending_in = 1'b0;
         cnt_in     = '0;
      end else if (is_data) begin
         pending_in = 1'b1;
         if (!mode_ff) begin
            tail_valid = sel_cur;
            col_in     = sat_inc(col_ff);
         end else if (req_data_byte == sep_ff) begin
            if (!delim_ff) begin
               delim_in = 1'b1;
               if (sel_cur) begin
                  flush_req   = 1'b1;
                  started_now = 1'b1;
               end
               cnt_in = '0;
            end
            fld_in = fld_next;
            if (sel_next) begin
               tail_valid = started_ff | started_now;
               tail_byte  = sep_ff;
               started_in = 1'b1;
            end else begin
               started_in = started_ff | started_now;
            end
         end else if (!delim_ff) begin
            // field one goes to the store, extra bytes dropped
            if (cnt_ff < CNT_W'(FIRST_FIELD_DEPTH)) begin
               store_we = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
            end
         end else begin
            tail_valid = sel_cur;
         end
      end
   end

   assign need_flush = flush_req & (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= POS_W'(1);
         fld_ff     <= POS_W'(1);
         delim_ff   <= 1'b0;
         started_ff <= 1'b0;
         pending_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (cmd.accept) begin
         col_ff     <= col_in;
         fld_ff     <= fld_in;
         delim_ff   <= delim_in;
         started_ff <= started_in;
         pending_ff <= pending_in;
         cnt_ff     <= cnt_in;
      end
   end

   // field one store, one write and one registered read port
   logic [7:0]       store_mem [FIRST_FIELD_DEPTH];
   logic [7:0]       mem_q_ff;
   logic             q_valid_ff, q_valid_in;
   logic [CNT_W-1:0] issue_ff, len_ff, left_ff;
   logic             tail_held_ff;
   logic [7:0]       tail_byte_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && store_we) begin
         store_mem[cnt_ff[ADDR_W-1:0]] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mem_q_ff <= store_mem[issue_ff[ADDR_W-1:0]];
      end
   end

   assign q_valid_in = cmd.issue | (q_valid_ff & ~cmd.load_flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && need_flush) begin
         issue_ff     <= '0;
         len_ff       <= cnt_ff;
         left_ff      <= cnt_ff;
         tail_held_ff <= tail_valid;
         tail_byte_ff <= tail_byte;
      end else begin
         if (cmd.issue) issue_ff <= issue_ff + CNT_W'(1);
         if (cmd.load_flush) left_ff <= left_ff - CNT_W'(1);
      end
   end

   // output register
   logic       rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [7:0] byte_ff, byte_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      priority if (cmd.accept && tail_valid && !need_flush) begin
         rsp_valid_in = 1'b1;
         byte_in      = tail_byte;
         last_in      = 1'b1;
      end else if (cmd.load_flush) begin
         rsp_valid_in = 1'b1;
         byte_in      = mem_q_ff;
         last_in      = (left_ff == CNT_W'(1)) & ~tail_held_ff;
      end else if (cmd.load_tail) begin
         rsp_valid_in = 1'b1;
         byte_in      = tail_byte_ff;
         last_in      = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

   assign status.out_free   = ~rsp_valid_ff | rsp_ready;
   assign status.need_flush = need_flush;
   assign status.issue_more = (issue_ff != len_ff);
   assign status.q_valid    = q_valid_ff;
   assign status.left_one   = (left_ff == CNT_W'(1));
   assign status.tail_held  = tail_held_ff;

endmodule

/* hw/rtl/line_byte_field_selector_top.sv */
// a result byte that needs no flush shows on rsp_ in the cycle after its request
// is accepted; throughput: one request per cycle while no stored first field is
// written out and the result channel is not stalled; a flush of stored field-one
// bytes is paced by the single read port of the field-one store
// reset: synchronous, active high; restores register defaults and line state,
// the field-one store is not cleared and needs no clearing pass
module line_byte_field_selector_top
   import lbfs_pkg::*;
#(
   parameter int unsigned NUM_RANGES        = 4,
   parameter int unsigned FIRST_FIELD_DEPTH = 63
)(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [7:0]            req_data_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   lbfs_cmd_type    cmd;
   lbfs_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: accepts a request, then walks the field-one flush and its tail byte
   lbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line state, range match, field-one store and output register
   lbfs_datapath #(
      .NUM_RANGES        (NUM_RANGES),
      .FIRST_FIELD_DEPTH (FIRST_FIELD_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

/* hw/rtl/lbfs_checker.sv */
module lbfs_checker
   import lbfs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_cmd,
   input logic [7:0]            req_data_byte,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_out_byte,
   input logic                  rsp_run_last,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // no new request while the output register is blocked
   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // a dropped carriage return produces no result
   a_cr_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_cmd && req_data_byte == CH_CR |=> !rsp_valid)
      else $error("result after carriage return");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind line_byte_field_selector_top lbfs_checker u_lbfs_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
   import lbfs_pkg::*;

   // request commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // range register indexes, following the package base
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_A = CSR_RANGE_BASE;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_B = CSR_RANGE_BASE + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_C = CSR_RANGE_BASE + 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_D = CSR_RANGE_BASE + 3'd3;

   localparam int FIRST_FIELD_DEPTH = 63;
   localparam int SETTLE_CYCLES     = 6;       // covers a request that yields nothing
   localparam int WATCHDOG_LIMIT    = 5000;    // cycles with no handshake at all
   localparam int NUM_PHASES        = 4;
   localparam int PHASE_REQUESTS    = 14;
   localparam int NUM_DIRECTED      = 32;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // result bytes typed in by hand for one request, used when fixed is set
   typedef struct packed {
      logic       fixed;
      logic [1:0] count;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } plan_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           value;   // register data, or the request byte in 7:0
      logic                  cmd;
      plan_type              plan;
   } step_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } owed_byte_type;

   localparam plan_type NO_FIXED = '0;

   // dut ports; the ones driven here are known from time zero
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_cmd       = CMD_BYTE;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_run_last;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = CSR_FIELD_MODE;
   logic [CSR_DATA_W-1:0] csr_data      = '0;

   // our copy of the registers, at their reset values
   logic        sel_field_mode = 1'b0;
   logic        sel_invert     = 1'b0;
   logic [7:0]  sel_separator  = CH_TAB;
   logic        sel_delim_only = 1'b0;
   logic [31:0] sel_range [4] = '{RANGE_RESET, RANGE_RESET, RANGE_RESET, RANGE_RESET};

   // our copy of the line state
   logic [POS_W-1:0] col_pos     = 1;
   logic [POS_W-1:0] field_num   = 1;
   logic             delim_seen  = 1'b0;
   logic             out_started = 1'b0;
   logic             line_open   = 1'b0;
   logic [7:0]       stash [FIRST_FIELD_DEPTH];
   int               stash_count = 0;

   logic [7:0]    cut_bytes [$];      // bytes one request gives
   owed_byte_type owed_bytes [$];     // result bytes still to come from the dut
   plan_type      request_plan [$];   // one entry per request handed to the dut
   plan_type      plan_now;
   owed_byte_type due;

   step_row_type directed_rows [NUM_DIRECTED];
   bit           full_rate    = 1'b0;   // both sides run without idling
   int           error_count  = 0;
   int           quiet_cycles = 0;

   line_byte_field_selector_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- selection

   // union of the four ranges, flipped when inverting
   function automatic logic in_selection(input logic [POS_W-1:0] pos);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 4; k++)
         if (pos >= sel_range[k][15:0] && pos <= sel_range[k][31:16]) hit = 1'b1;
      return hit ^ sel_invert;
   endfunction

   task automatic spill_stash();
      for (int k = 0; k < stash_count; k++) cut_bytes.push_back(stash[k]);
   endtask

   // newline or end of input: a field-mode line with no delimiter goes out as stored, unless delim-only is set
   task automatic close_line();
      if (sel_field_mode && !delim_seen) begin
         if (!sel_delim_only) begin
            spill_stash();
            cut_bytes.push_back(CH_LF);
         end
      end else begin
         cut_bytes.push_back(CH_LF);
      end
      col_pos     = 1;
      field_num   = 1;
      delim_seen  = 1'b0;
      out_started = 1'b0;
      line_open   = 1'b0;
      stash_count = 0;
   endtask

   // the bytes one request produces, left in cut_bytes
   task automatic extract_request(input logic cmd, input logic [7:0] b);
      cut_bytes.delete();
      if (cmd == CMD_END) begin
         if (line_open) close_line();
      end else if (b == CH_LF) begin
         close_line();
      end else if (b != CH_CR) begin
         line_open = 1'b1;
         if (!sel_field_mode) begin
            if (in_selection(col_pos)) cut_bytes.push_back(b);
            if (col_pos != POS_MAX) col_pos++;
         end else if (b == sel_separator) begin
            // first delimiter decides what happens to the held field one
            if (!delim_seen) begin
               delim_seen = 1'b1;
               if (in_selection(field_num)) begin
                  spill_stash();
                  out_started = 1'b1;
               end
               stash_count = 0;
            end
            if (field_num != POS_MAX) field_num++;
            if (in_selection(field_num)) begin
               if (out_started) cut_bytes.push_back(sel_separator);
               out_started = 1'b1;
            end
         end else if (!delim_seen) begin
            // field one bytes past the store depth are lost
            if (stash_count < FIRST_FIELD_DEPTH) begin
               stash[stash_count] = b;
               stash_count++;
            end
         end else if (in_selection(field_num)) begin
            cut_bytes.push_back(b);
         end
      end
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      case (idx)
         CSR_FIELD_MODE: sel_field_mode = value[0];
         CSR_INVERT:     sel_invert     = value[0];
         CSR_SEPARATOR:  sel_separator  = value[7:0];
         CSR_DELIM_ONLY: sel_delim_only = value[0];
         default:        sel_range[idx[1:0]] = value;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s, got %02h want %02h", $realtime, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- monitor

   // every handshake is sampled at the edge where it completes, before any
   // driver update of that edge lands
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && req_ready) begin
            plan_now = request_plan.pop_front();
            extract_request(req_cmd, req_data_byte);
            // hand-typed rows replace the computed bytes, state still moves on
            if (plan_now.fixed) begin
               cut_bytes.delete();
               if (plan_now.count >= 1) cut_bytes.push_back(plan_now.first_byte);
               if (plan_now.count == 2) cut_bytes.push_back(plan_now.second_byte);
            end
            for (int k = 0; k < cut_bytes.size(); k++)
               owed_bytes.push_back('{out_byte: cut_bytes[k],
                                      run_last: (k == cut_bytes.size() - 1)});
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               report_mismatch("result byte with nothing owed", rsp_out_byte, 8'h00);
            end else begin
               due = owed_bytes.pop_front();
               if (rsp_out_byte !== due.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, due.out_byte);
               if (rsp_run_last !== due.run_last)
                  report_mismatch("run_last", 8'(rsp_run_last), 8'(due.run_last));
            end
         end
      end
   end

   // receiver stalls about a third of the cycles unless running at full rate
   always @(posedge clock) rsp_ready <= full_rate ? 1'b1 : ($urandom_range(0, 2) != 0);

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // one request, with random gaps before it; valid stays up until taken
   task automatic send_request(input logic cmd, input logic [7:0] b, input plan_type plan);
      while (!full_rate && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      request_plan.push_back(plan);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // register writes wait for the block to go quiet
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic mode, input logic inv, input logic [7:0] sep,
                                 input logic only, input logic [31:0] ra,
                                 input logic [31:0] rb, input logic [31:0] rc,
                                 input logic [31:0] rd);
      write_register(CSR_FIELD_MODE, 32'(mode));
      write_register(CSR_INVERT, 32'(inv));
      write_register(CSR_SEPARATOR, 32'(sep));
      write_register(CSR_DELIM_ONLY, 32'(only));
      write_register(CSR_RANGE_A, ra);
      write_register(CSR_RANGE_B, rb);
      write_register(CSR_RANGE_C, rc);
      write_register(CSR_RANGE_D, rd);
   endtask

   // ---------------------------------------------------------------- random picks

   // small ranges, plus empty, full and wild ones
   function automatic logic [31:0] pick_range();
      logic [15:0] lo;
      lo = 16'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
         0:       return RANGE_RESET;
         1:       return 32'hFFFF_0000;        // everything
         2:       return 32'h0000_FFFF;        // low above high, nothing
         3:       return $urandom();
         default: return {lo + 16'($urandom_range(0, 3)), lo};
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 7))
         0:       return CH_TAB;
         1:       return 8'h00;
         2:       return 8'hFF;
         3:       return $urandom_range(0, 1) ? CH_LF : CH_CR;   // never seen as a delimiter
         4:       return 8'($urandom_range(0, 255));
         default: return 8'h2c;                                  // comma
      endcase
   endfunction

   // lowercase text with the odd carriage return or arbitrary byte
   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 11))
         0:       return CH_CR;
         1:       return 8'($urandom_range(0, 255));
         default: return 8'h61 + 8'($urandom_range(0, 25));
      endcase
   endfunction

   // mostly well-formed lines of fields, plus noise and unterminated lines
   task automatic send_random_text(input int budget);
      int left;
      int nfields;
      int len;
      left = budget;
      while (left > 0) begin
         case ($urandom_range(0, 9))
            0: begin
               send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), NO_FIXED);
               left--;
            end
            1: begin
               send_request(CMD_END, 8'($urandom_range(0, 255)), NO_FIXED);
               left--;
            end
            default: begin
               nfields = $urandom_range(1, 4);
               for (int f = 0; f < nfields; f++) begin
                  if (f > 0) begin
                     send_request(CMD_BYTE, sel_separator, NO_FIXED);
                     left--;
                  end
                  // now and then a field one near or past the store depth
                  if (f == 0 && $urandom_range(0, 24) == 0)
                     len = $urandom_range(60, 70);
                  else
                     len = $urandom_range(0, 4);
                  repeat (len) begin
                     send_request(CMD_BYTE, text_byte(), NO_FIXED);
                     left--;
                  end
               end
               if ($urandom_range(0, 3) != 0) begin
                  send_request(CMD_BYTE, CH_LF, NO_FIXED);
                  left--;
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- directed table

   function automatic step_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [31:0] value);
      return '{kind: ROW_CSR, index: idx, value: value, cmd: CMD_BYTE, plan: NO_FIXED};
   endfunction

   // request checked against the computed bytes
   function automatic step_row_type byte_row(input logic cmd, input logic [7:0] b);
      return '{kind: ROW_REQ, index: CSR_FIELD_MODE, value: 32'(b), cmd: cmd, plan: NO_FIXED};
   endfunction

   // request with its result bytes typed in
   function automatic step_row_type fixed_row(input logic cmd, input logic [7:0] b,
                                              input logic [1:0] count,
                                              input logic [7:0] b0, input logic [7:0] b1);
      return '{kind: ROW_REQ, index: CSR_FIELD_MODE, value: 32'(b), cmd: cmd,
               plan: '{fixed: 1'b1, count: count, first_byte: b0, second_byte: b1}};
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      directed_rows = '{
         // reset settings: byte mode with empty ranges keeps only newlines
         fixed_row(CMD_BYTE, 8'h61, 2'd0, 8'h00, 8'h00),
         fixed_row(CMD_BYTE, CH_CR, 2'd0, 8'h00, 8'h00),
         fixed_row(CMD_BYTE, CH_LF, 2'd1, CH_LF, 8'h00),
         fixed_row(CMD_END, 8'h00, 2'd0, 8'h00, 8'h00),          // end with no line open
         // inverted empty ranges select every byte, extremes of the data
         csr_row(CSR_INVERT, 32'd1),
         fixed_row(CMD_BYTE, 8'hFF, 2'd1, 8'hFF, 8'h00),
         fixed_row(CMD_BYTE, 8'h00, 2'd1, 8'h00, 8'h00),
         fixed_row(CMD_END, 8'hFF, 2'd1, CH_LF, 8'h00),          // end closes the line
         // field two of a tab-separated line
         csr_row(CSR_FIELD_MODE, 32'd1),
         csr_row(CSR_INVERT, 32'd0),
         csr_row(CSR_RANGE_A, 32'h0002_0002),
         byte_row(CMD_BYTE, 8'h61),
         byte_row(CMD_BYTE, 8'h62),
         byte_row(CMD_BYTE, CH_TAB),
         byte_row(CMD_BYTE, 8'h63),
         byte_row(CMD_BYTE, CH_TAB),
         byte_row(CMD_BYTE, 8'h64),
         byte_row(CMD_BYTE, CH_LF),
         // line without delimiter suppressed
         csr_row(CSR_DELIM_ONLY, 32'd1),
         fixed_row(CMD_BYTE, 8'h78, 2'd0, 8'h00, 8'h00),
         fixed_row(CMD_BYTE, 8'h79, 2'd0, 8'h00, 8'h00),
         fixed_row(CMD_BYTE, CH_LF, 2'd0, 8'h00, 8'h00),
         // line without delimiter passed through, closed by end of input
         csr_row(CSR_DELIM_ONLY, 32'd0),
         fixed_row(CMD_BYTE, 8'h7a, 2'd0, 8'h00, 8'h00),
         fixed_row(CMD_END, 8'h00, 2'd2, 8'h7a, CH_LF),
         // all fields selected, empty ones still joined
         csr_row(CSR_RANGE_A, 32'hFFFF_0000),
         byte_row(CMD_BYTE, CH_TAB),
         byte_row(CMD_BYTE, CH_TAB),
         byte_row(CMD_BYTE, CH_LF),
         // newline as delimiter is never seen as one
         csr_row(CSR_SEPARATOR, 32'(CH_LF)),
         byte_row(CMD_BYTE, 8'h71),
         byte_row(CMD_BYTE, CH_LF)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_register(directed_rows[i].index, directed_rows[i].value);
         else
            send_request(directed_rows[i].cmd, directed_rows[i].value[7:0],
                         directed_rows[i].plan);
      end

      // random settings per phase, one phase with no idling on either side
      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_separator(),
                        1'($urandom_range(0, 1)), pick_range(), pick_range(), pick_range(),
                        pick_range());
         full_rate = (p == 1);
         send_random_text(PHASE_REQUESTS);
      end
      full_rate = 1'b0;

      // field one past the store depth, flushed by end of input under stalls
      apply_settings(1'b1, 1'b1, CH_TAB, 1'b0, RANGE_RESET, RANGE_RESET, RANGE_RESET,
                     RANGE_RESET);
      for (int k = 0; k < 70; k++)
         send_request(CMD_BYTE, 8'h41 + 8'(k % 26), NO_FIXED);
      send_request(CMD_END, 8'h00, NO_FIXED);

      // drain whatever is still owed, then a short quiet tail
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/lbfs_pkg.sv
hw/rtl/lbfs_ctrl.sv
hw/rtl/lbfs_datapath.sv
hw/rtl/line_byte_field_selector_top.sv
hw/rtl/lbfs_checker.sv
bench/tb.sv
